// ===== hw/rtl/crcpr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crcpr_pkg
// Shared types, constants and the CRC-16 byte update for the packet receiver.
// ----------------------------------------------------------------------------
package crcpr_pkg;

   // Bytes kept per packet; anything beyond is dropped (range 19..256).
   localparam int BUFFER_BYTES = 64;
   localparam int COUNT_W      = $clog2(BUFFER_BYTES + 1);

   // Packet layout
   localparam int MIN_BYTES      = 3;   // opcode plus two crc bytes
   localparam int ATT_CRC_HI_POS = 17;  // attitude crc high byte position
   localparam int ATT_CRC_LO_POS = 18;  // attitude crc low byte position
   localparam int ATT_BYTES      = 19;  // checked length of an attitude packet
   localparam int PAYLOAD_LAST   = 16;  // last payload byte position
   localparam int PAYLOAD_WORDS  = 4;

   localparam logic [15:0] CRC_INIT     = 16'hFFFF;
   localparam logic [15:0] CRC_POLY     = 16'h8005;
   localparam logic [15:0] CRC_XOR_OUT  = 16'hFFFF;
   localparam logic [7:0]  ATT_OPC_INIT = 8'd1;

   // Front-to-back queue depth
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      STATUS_SIMPLE_OK   = 2'd0,
      STATUS_ATTITUDE_OK = 2'd1,
      STATUS_CRC_BAD     = 2'd2,
      STATUS_TOO_SHORT   = 2'd3
   } status_type;

   typedef logic [PAYLOAD_WORDS-1:0][3:0][7:0] payload_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       end_of_packet;
   } req_item_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  opcode;
      logic [31:0] roll_bits;
      logic [31:0] pitch_bits;
      logic [31:0] yaw_bits;
      logic [31:0] throttle_bits;
      logic [31:0] good_count;
      logic [31:0] bad_count;
   } rsp_item_type;

   // Everything the back end needs to judge one finished packet.
   typedef struct packed {
      logic [COUNT_W-1:0] byte_count;
      logic [7:0]         first_byte;
      logic [7:0]         trail_hi;
      logic [7:0]         trail_lo;
      logic [15:0]        crc;
      logic [15:0]        crc_at_17;
      logic [15:0]        crc_bytes_at_17;
      payload_type        payload;
   } pkt_summary_type;

   // Reflected-shift update through an MSB-first 0x8005 table entry.
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] v;
      v = {crc[7:0] ^ b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (v[15]) begin
            v = {v[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            v = {v[14:0], 1'b0};
         end
      end
      return {8'h00, crc[15:8]} ^ v;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/crcpr_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crcpr_front
// Per-byte packet accumulator: crc, trailer delay line, payload capture.
// Emits one packet summary on the end-of-packet byte.
// ----------------------------------------------------------------------------
module crcpr_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       accept,
   input  wire crcpr_pkg::req_item_type    item,
   output      logic                       sum_push,
   output      crcpr_pkg::pkt_summary_type sum_data
);

   localparam int CW = crcpr_pkg::COUNT_W;

   logic [CW-1:0]          count_ff, count_in, count_upd;
   logic [7:0]             first_ff, first_in, first_upd;
   logic [7:0]             trail_hi_ff, trail_hi_in, trail_hi_upd;
   logic [7:0]             trail_lo_ff, trail_lo_in, trail_lo_upd;
   logic [15:0]            crc_ff, crc_in, crc_upd;
   logic [15:0]            crc17_ff, crc17_in, crc17_upd;
   logic [15:0]            crcb17_ff, crcb17_in, crcb17_upd;
   crcpr_pkg::payload_type payload_ff, payload_in, payload_upd;
   logic [3:0]             pos;
   logic                   in_buffer;

   assign pos       = 4'(count_ff - CW'(1));
   assign in_buffer = (count_ff < CW'(crcpr_pkg::BUFFER_BYTES));

   always_comb begin
      count_upd    = count_ff;
      first_upd    = first_ff;
      trail_hi_upd = trail_hi_ff;
      trail_lo_upd = trail_lo_ff;
      crc_upd      = crc_ff;
      crc17_upd    = crc17_ff;
      crcb17_upd   = crcb17_ff;
      payload_upd  = payload_ff;
      if (in_buffer) begin
         // crc runs two bytes behind so the trailer never enters it
         if (count_ff >= CW'(2)) begin
            crc_upd = crcpr_pkg::crc_feed(crc_ff, trail_hi_ff);
         end
         trail_hi_upd = trail_lo_ff;
         trail_lo_upd = item.rx_byte;
         if (count_ff == '0) begin
            first_upd = item.rx_byte;
         end
         if (count_ff >= CW'(1) && count_ff <= CW'(crcpr_pkg::PAYLOAD_LAST)) begin
            payload_upd[pos[3:2]][pos[1:0]] = item.rx_byte;
         end
         if (count_ff == CW'(crcpr_pkg::ATT_CRC_HI_POS)) begin
            crcb17_upd = {item.rx_byte, 8'h00};
         end
         if (count_ff == CW'(crcpr_pkg::ATT_CRC_LO_POS)) begin
            crcb17_upd = {crcb17_ff[15:8], item.rx_byte};
            crc17_upd  = crc_upd;
         end
         count_upd = count_ff + CW'(1);
      end
   end

   assign sum_push = accept & item.end_of_packet;

   always_comb begin
      sum_data.byte_count      = count_upd;
      sum_data.first_byte      = first_upd;
      sum_data.trail_hi        = trail_hi_upd;
      sum_data.trail_lo        = trail_lo_upd;
      sum_data.crc             = crc_upd;
      sum_data.crc_at_17       = crc17_upd;
      sum_data.crc_bytes_at_17 = crcb17_upd;
      sum_data.payload         = payload_upd;
   end

   always_comb begin
      count_in    = count_ff;
      first_in    = first_ff;
      trail_hi_in = trail_hi_ff;
      trail_lo_in = trail_lo_ff;
      crc_in      = crc_ff;
      crc17_in    = crc17_ff;
      crcb17_in   = crcb17_ff;
      payload_in  = payload_ff;
      if (accept) begin
         if (item.end_of_packet) begin
            count_in    = '0;
            first_in    = '0;
            trail_hi_in = '0;
            trail_lo_in = '0;
            crc_in      = crcpr_pkg::CRC_INIT;
            crc17_in    = '0;
            crcb17_in   = '0;
            payload_in  = '0;
         end else begin
            count_in    = count_upd;
            first_in    = first_upd;
            trail_hi_in = trail_hi_upd;
            trail_lo_in = trail_lo_upd;
            crc_in      = crc_upd;
            crc17_in    = crc17_upd;
            crcb17_in   = crcb17_upd;
            payload_in  = payload_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         first_ff    <= '0;
         trail_hi_ff <= '0;
         trail_lo_ff <= '0;
         crc_ff      <= crcpr_pkg::CRC_INIT;
         crc17_ff    <= '0;
         crcb17_ff   <= '0;
         payload_ff  <= '0;
      end else begin
         count_ff    <= count_in;
         first_ff    <= first_in;
         trail_hi_ff <= trail_hi_in;
         trail_lo_ff <= trail_lo_in;
         crc_ff      <= crc_in;
         crc17_ff    <= crc17_in;
         crcb17_ff   <= crcb17_in;
         payload_ff  <= payload_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/crcpr_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crcpr_queue
// Short register queue of packet summaries between front and back.
// ----------------------------------------------------------------------------
module crcpr_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire crcpr_pkg::pkt_summary_type push_data,
   input  wire logic                       pop,
   output      crcpr_pkg::pkt_summary_type pop_data,
   output      logic                       full,
   output      logic                       empty
);

   localparam int PW = crcpr_pkg::QPTR_W;
   localparam int NW = crcpr_pkg::QCNT_W;

   crcpr_pkg::pkt_summary_type mem [crcpr_pkg::QUEUE_DEPTH];

   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full    = (count_ff == NW'(crcpr_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign pop_data = mem[rd_ptr_ff];

   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
      if (p == PW'(crcpr_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + PW'(1);
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + NW'(do_push) - NW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/crcpr_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crcpr_back
// Packet judge: crc compare, classification, totals, result register.
// Also holds the attitude opcode register.
// ----------------------------------------------------------------------------
module crcpr_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_write_en,
   input  wire logic [7:0]                 csr_write_data,
   input  wire logic                       sum_valid,
   input  wire crcpr_pkg::pkt_summary_type sum_data,
   output      logic                       sum_pop,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_taken,
   output      crcpr_pkg::rsp_item_type    rsp_item
);

   localparam int CW = crcpr_pkg::COUNT_W;

   logic [7:0]              att_opc_ff, att_opc_in;
   logic [31:0]             good_ff, good_in;
   logic [31:0]             bad_ff, bad_in;
   logic                    valid_ff, valid_in;
   crcpr_pkg::rsp_item_type item_ff, item_in;
   logic                    load;
   logic                    is_short, is_attitude, att_match, simple_match;

   assign load    = sum_valid & (~valid_ff | rsp_taken);
   assign sum_pop = load;

   assign is_short    = (sum_data.byte_count < CW'(crcpr_pkg::MIN_BYTES));
   assign is_attitude = (sum_data.first_byte == att_opc_ff) &&
                        (sum_data.byte_count >= CW'(crcpr_pkg::ATT_BYTES));
   assign att_match    = ((sum_data.crc_at_17 ^ crcpr_pkg::CRC_XOR_OUT) ==
                          sum_data.crc_bytes_at_17);
   assign simple_match = ((sum_data.crc ^ crcpr_pkg::CRC_XOR_OUT) ==
                          {sum_data.trail_hi, sum_data.trail_lo});

   always_comb begin
      att_opc_in = csr_write_en ? csr_write_data : att_opc_ff;
      good_in    = good_ff;
      bad_in     = bad_ff;
      item_in    = item_ff;
      valid_in   = valid_ff & ~rsp_taken;
      if (load) begin
         valid_in              = 1'b1;
         item_in.opcode        = sum_data.first_byte;
         item_in.roll_bits     = '0;
         item_in.pitch_bits    = '0;
         item_in.yaw_bits      = '0;
         item_in.throttle_bits = '0;
         if (is_short) begin
            item_in.status = crcpr_pkg::STATUS_TOO_SHORT;
         end else if (is_attitude) begin
            if (att_match) begin
               item_in.status        = crcpr_pkg::STATUS_ATTITUDE_OK;
               item_in.roll_bits     = sum_data.payload[0];
               item_in.pitch_bits    = sum_data.payload[1];
               item_in.yaw_bits      = sum_data.payload[2];
               item_in.throttle_bits = sum_data.payload[3];
               good_in               = good_ff + 32'd1;
            end else begin
               item_in.status = crcpr_pkg::STATUS_CRC_BAD;
               bad_in         = bad_ff + 32'd1;
            end
         end else if (simple_match) begin
            item_in.status = crcpr_pkg::STATUS_SIMPLE_OK;
            good_in        = good_ff + 32'd1;
         end else begin
            item_in.status = crcpr_pkg::STATUS_CRC_BAD;
            bad_in         = bad_ff + 32'd1;
         end
         item_in.good_count = good_in;
         item_in.bad_count  = bad_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         att_opc_ff <= crcpr_pkg::ATT_OPC_INIT;
         good_ff    <= '0;
         bad_ff     <= '0;
         valid_ff   <= 1'b0;
      end else begin
         att_opc_ff <= att_opc_in;
         good_ff    <= good_in;
         bad_ff     <= bad_in;
         valid_ff   <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/crc16_command_packet_receiver_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crc16_command_packet_receiver_core
// Byte-stream packet receiver with CRC-16 check, attitude payload extraction
// and good/bad packet totals.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, back-to-back packets too, unless req_full is high.
// A result reaches the rsp_ ports once its summary, written into the queue on the edge
//   that accepts its last byte, has moved into the result register.
// The crc byte update is one table step per accepted byte, in the front end.
// Reset (synchronous, active high): queues empty, totals zero, packet state
//   cleared, attitude opcode back to 1. No clearing pass.
// ----------------------------------------------------------------------------
module crc16_command_packet_receiver_core (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // input byte channel
   input  wire logic                    req_push,
   output      logic                    req_full,
   input  wire crcpr_pkg::req_item_type req_item,
   // result channel
   output      logic                    rsp_empty,
   input  wire logic                    rsp_pop,
   output      crcpr_pkg::rsp_item_type rsp_item,
   // attitude opcode register
   input  wire logic                    csr_write_en,
   input  wire logic [7:0]              csr_write_data
);

   // Front and back are decoupled by a two-entry summary queue. The front
   // only needs queue space on an end-of-packet byte, but it stalls on a full
   // queue; with the result register draining, the queue never stays full,
   // so bytes flow one per cycle.
   logic                       req_accept;
   logic                       sum_push;
   crcpr_pkg::pkt_summary_type sum_push_data;
   crcpr_pkg::pkt_summary_type sum_pop_data;
   logic                       sum_pop;
   logic                       q_full;
   logic                       q_empty;
   logic                       rsp_valid;

   assign req_full   = q_full;
   assign req_accept = req_push & ~q_full;

   crcpr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .item     (req_item),
      .sum_push (sum_push),
      .sum_data (sum_push_data)
   );

   crcpr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (sum_push),
      .push_data (sum_push_data),
      .pop       (sum_pop),
      .pop_data  (sum_pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   // Back end: the result register frees as soon as it is popped, so a new
   // item can load in the same cycle the old one leaves.
   crcpr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .sum_valid      (~q_empty),
      .sum_data       (sum_pop_data),
      .sum_pop        (sum_pop),
      .rsp_valid      (rsp_valid),
      .rsp_taken      (rsp_pop),
      .rsp_item       (rsp_item)
   );

   assign rsp_empty = ~rsp_valid;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------

   // payload words only carry data on an accepted attitude item
   a_payload_zero : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_item.status != crcpr_pkg::STATUS_ATTITUDE_OK) |->
      (rsp_item.roll_bits == '0 && rsp_item.pitch_bits == '0 &&
       rsp_item.yaw_bits == '0 && rsp_item.throttle_bits == '0))
      else $error("payload words set on a non-attitude item");

   // queue cannot be both full and empty
   a_queue_flags : assert property (@(posedge clock) disable iff (reset)
      !(q_full && q_empty))
      else $error("summary queue full and empty at once");

   // nothing to deliver right after reset
   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> (rsp_empty && q_empty))
      else $error("item present right after reset");

   // a short packet leaves both totals alone relative to the previous item
   a_short_no_count : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop) ##1
      (!rsp_empty && rsp_item.status == crcpr_pkg::STATUS_TOO_SHORT) |->
      (rsp_item.good_count == $past(rsp_item.good_count) &&
       rsp_item.bad_count == $past(rsp_item.bad_count)))
      else $error("too-short item changed a total");

endmodule
`default_nettype wire
